// File: rtl/orl_pkg.sv
package orl_pkg;

  localparam int KEY_W   = 16;
  localparam int GRADE_W = 10;
  localparam int CMD_W   = 3;
  localparam int STAT_W  = 2;

  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [KEY_W-1:0]   key;
    logic [GRADE_W-1:0] grade;
  } orl_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [KEY_W-1:0]   found_key;
    logic [GRADE_W-1:0] found_grade;
    logic               last;
  } orl_rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [GRADE_W-1:0] grade;
  } orl_entry_t;

endpackage

// File: rtl/ordered_record_list_top.sv
// Insertion-ordered store of up to ENTRIES records (16-bit key, 10-bit grade in
// hundredths), held packed in a memory with a write port and a registered read port.
// One request is handled at a time; in_stall stays high while a request is at work
// and while its last result waits in the output register. Append and clear finish
// in the idle state. Lookup reads one record per cycle through the memory read port
// and stops on the first hit or after the last record. Remove is the same search
// followed by a compaction that moves one record per cycle; a miss skips it.
// Dump emits one record per cycle while out_stall is low or no result is pending.
// The registered memory read port paces these searches and walks. Lookup, dump,
// remove and clear on an empty store answer with status empty; commands 5 to 7
// produce no result.
module ordered_record_list_top
  import orl_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  orl_req_t in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output orl_rsp_t out_rsp
);

  localparam int CNTW = $clog2(ENTRIES + 1);
  localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT, S_DUMP} state_t;

  state_t             state_r, state_nxt;
  logic [CNTW-1:0]    count_r, count_nxt;
  logic [CNTW-1:0]    idx_r, idx_nxt;
  logic [IDXW-1:0]    chk_idx_r, chk_idx_nxt;
  logic               chk_v_r, chk_v_nxt;
  logic [CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  orl_entry_t         res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  orl_rsp_t           out_rsp_r, out_rsp_nxt;

  orl_entry_t         mem [ENTRIES];
  orl_entry_t         rd_data_r;
  logic               rd_en;
  logic [IDXW-1:0]    rd_addr;
  logic               wr_en;
  logic [IDXW-1:0]    wr_addr;
  orl_entry_t         wr_data;

  logic               accept;
  logic               out_free;
  logic               load;
  orl_rsp_t           load_rsp;
  logic               match;
  logic               issue;

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;
  assign match     = chk_v_r && (rd_data_r.key == key_r);
  assign issue     = idx_r < count_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    chk_idx_nxt = chk_idx_r;
    chk_v_nxt   = chk_v_r;
    cmd_nxt     = cmd_r;
    key_nxt     = key_r;
    res_nxt     = res_r;
    rd_en       = 1'b0;
    rd_addr     = idx_r[IDXW-1:0];
    wr_en       = 1'b0;
    wr_addr     = count_r[IDXW-1:0];
    wr_data     = '{key: in_req.key, grade: in_req.grade};
    load        = 1'b0;
    load_rsp    = '{status: ST_OK, found_key: '0, found_grade: '0, last: 1'b1};

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt     = in_req.cmd;
          key_nxt     = in_req.key;
          idx_nxt     = '0;
          chk_v_nxt   = 1'b0;
          if (in_req.cmd == CMD_APPEND) begin
            load = 1'b1;
            if (count_r == CNTW'(ENTRIES)) begin
              load_rsp.status = ST_FULL;
            end else begin
              wr_en     = 1'b1;
              count_nxt = count_r + CNTW'(1);
            end
          end else if (in_req.cmd == CMD_LOOKUP || in_req.cmd == CMD_DUMP ||
                       in_req.cmd == CMD_REMOVE || in_req.cmd == CMD_CLEAR) begin
            if (count_r == '0) begin
              load            = 1'b1;
              load_rsp.status = ST_EMPTY;
            end else if (in_req.cmd == CMD_CLEAR) begin
              load      = 1'b1;
              count_nxt = '0;
            end else if (in_req.cmd == CMD_DUMP) begin
              state_nxt = S_DUMP;
            end else begin
              state_nxt = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if (match) begin
          chk_v_nxt = 1'b0;
          if (cmd_r == CMD_LOOKUP) begin
            load                 = 1'b1;
            load_rsp.found_key   = rd_data_r.key;
            load_rsp.found_grade = rd_data_r.grade;
            state_nxt            = S_IDLE;
          end else begin
            res_nxt   = rd_data_r;
            idx_nxt   = CNTW'(chk_idx_r) + CNTW'(1);
            state_nxt = S_SHIFT;
          end
        end else if (chk_v_r && !issue) begin
          chk_v_nxt       = 1'b0;
          load            = 1'b1;
          load_rsp.status = ST_NOTFOUND;
          state_nxt       = S_IDLE;
        end else begin
          rd_en       = issue;
          chk_v_nxt   = issue;
          chk_idx_nxt = idx_r[IDXW-1:0];
          if (issue) begin
            idx_nxt = idx_r + CNTW'(1);
          end
        end
      end
      S_SHIFT: begin
        if (chk_v_r) begin
          wr_en   = 1'b1;
          wr_addr = chk_idx_r - IDXW'(1);
          wr_data = rd_data_r;
        end
        if (!chk_v_r && !issue) begin
          count_nxt            = count_r - CNTW'(1);
          load                 = 1'b1;
          load_rsp.found_key   = res_r.key;
          load_rsp.found_grade = res_r.grade;
          state_nxt            = S_IDLE;
        end else begin
          rd_en       = issue;
          chk_v_nxt   = issue;
          chk_idx_nxt = idx_r[IDXW-1:0];
          if (issue) begin
            idx_nxt = idx_r + CNTW'(1);
          end
        end
      end
      S_DUMP: begin
        if (!chk_v_r || out_free) begin
          if (chk_v_r) begin
            load                 = 1'b1;
            load_rsp.found_key   = rd_data_r.key;
            load_rsp.found_grade = rd_data_r.grade;
            load_rsp.last        = (CNTW'(chk_idx_r) + CNTW'(1)) == count_r;
          end
          rd_en       = issue;
          chk_v_nxt   = issue;
          chk_idx_nxt = idx_r[IDXW-1:0];
          if (issue) begin
            idx_nxt = idx_r + CNTW'(1);
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = (out_valid_r && out_stall) || load;
    out_rsp_nxt   = load ? load_rsp : out_rsp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      chk_v_r     <= chk_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r     <= idx_nxt;
    chk_idx_r <= chk_idx_nxt;
    cmd_r     <= cmd_nxt;
    key_r     <= key_nxt;
    res_r     <= res_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(ENTRIES))
    else $error("record count above capacity");

  a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !chk_v_r)
    else $error("read pipeline busy while idle");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> out_free)
    else $error("result overwrites a pending result");

  a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && state_nxt == S_IDLE) |=> count_r == $past(count_r) - CNTW'(1))
    else $error("remove did not drop one record");

endmodule

// File: bench/orl_checker.sv
module orl_checker
  import orl_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  orl_req_t in_req,
  input  logic     out_valid,
  input  logic     out_stall,
  input  orl_rsp_t out_rsp,
  output int       mismatches,
  output int       outstanding
);

  orl_entry_t records [ENTRIES];
  int         held;
  orl_rsp_t   rsp_due [$];
  orl_rsp_t   want;
  int         bad;

  function automatic orl_rsp_t make_rsp(input logic [STAT_W-1:0] s, input orl_entry_t e,
                                        input logic fin);
    orl_rsp_t r;
    r.status      = s;
    r.found_key   = e.key;
    r.found_grade = e.grade;
    r.last        = fin;
    return r;
  endfunction

  task automatic apply_request(input orl_req_t r);
    orl_entry_t e;
    int hit;
    hit = -1;
    e.key   = r.key;
    e.grade = r.grade;
    for (int i = 0; i < held; i++) begin
      if (hit < 0 && records[i].key == r.key) hit = i;
    end
    if (r.cmd > CMD_CLEAR) begin
      // unknown commands are dropped without a result
    end else if (r.cmd == CMD_APPEND) begin
      if (held >= ENTRIES) begin
        rsp_due.push_back(make_rsp(ST_FULL, '0, 1'b1));
      end else begin
        records[held] = e;
        held++;
        rsp_due.push_back(make_rsp(ST_OK, '0, 1'b1));
      end
    end else if (held == 0) begin
      rsp_due.push_back(make_rsp(ST_EMPTY, '0, 1'b1));
    end else begin
      case (r.cmd)
        CMD_LOOKUP: begin
          if (hit < 0) rsp_due.push_back(make_rsp(ST_NOTFOUND, '0, 1'b1));
          else rsp_due.push_back(make_rsp(ST_OK, records[hit], 1'b1));
        end
        CMD_DUMP: begin
          for (int i = 0; i < held; i++)
            rsp_due.push_back(make_rsp(ST_OK, records[i], i == held - 1));
        end
        CMD_REMOVE: begin
          if (hit < 0) begin
            rsp_due.push_back(make_rsp(ST_NOTFOUND, '0, 1'b1));
          end else begin
            rsp_due.push_back(make_rsp(ST_OK, records[hit], 1'b1));
            for (int i = hit; i + 1 < held; i++) records[i] = records[i + 1];
            held--;
          end
        end
        default: begin
          held = 0;
          rsp_due.push_back(make_rsp(ST_OK, '0, 1'b1));
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_due.delete();
      held = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (rsp_due.size() == 0) begin
          bad++;
          if (bad <= 10)
            $display("%0t: unexpected result status %0d key %h grade %0d last %0b", $realtime,
                     out_rsp.status, out_rsp.found_key, out_rsp.found_grade, out_rsp.last);
        end else begin
          want = rsp_due.pop_front();
          if (out_rsp.status !== want.status || out_rsp.found_key !== want.found_key ||
              out_rsp.found_grade !== want.found_grade || out_rsp.last !== want.last) begin
            bad++;
            if (bad <= 10)
              $display("%0t: mismatch exp status %0d key %h grade %0d last %0b, got %0d %h %0d %0b",
                       $realtime, want.status, want.found_key, want.found_grade, want.last,
                       out_rsp.status, out_rsp.found_key, out_rsp.found_grade, out_rsp.last);
          end
        end
      end
      if (in_valid && !in_stall) apply_request(in_req);
    end
    mismatches  <= bad;
    outstanding <= rsp_due.size();
  end

endmodule

// File: bench/testbench.sv
module testbench;
  import orl_pkg::*;

  localparam int DEPTH           = 16;
  localparam int RANDOM_REQUESTS = 400;
  localparam int TIMEOUT         = 2000000;
  localparam int POOL            = 8;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_kind_e;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  orl_req_t in_req    = '0;
  logic     out_stall = 1'b0;
  logic     in_stall;
  logic     out_valid;
  orl_rsp_t out_rsp;

  int mismatches;
  int outstanding;

  logic [KEY_W-1:0] key_pool [POOL];
  int               burst_left  = 1;
  stall_kind_e      stall_kind  = STALL_NONE;
  int               stall_left  = 0;
  int               stall_phase = 0;

  always #2 clk = ~clk;

  ordered_record_list_top #(.ENTRIES(DEPTH)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_rsp  (out_rsp)
  );

  orl_checker #(.ENTRIES(DEPTH)) record_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_rsp    (out_rsp),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_kind = stall_kind_e'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 96);
    end
    stall_left--;
    stall_phase++;
    case (stall_kind)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_phase % 3 != 0);
    endcase
  end

  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, POOL - 1)];
    else k = KEY_W'($urandom);
    return k;
  endfunction

  function automatic logic [GRADE_W-1:0] pick_grade();
    logic [GRADE_W-1:0] g;
    if ($urandom_range(0, 4) != 0) g = GRADE_W'($urandom_range(0, 1000));
    else g = GRADE_W'($urandom);
    return g;
  endfunction

  // one request; valid stays up across a burst and drops for the gap after it
  task automatic issue(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
                       input logic [GRADE_W-1:0] g);
    int gap;
    in_req   <= '{c, k, g};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    int kind;
    int n;
    int sent;
    int next_drain;
    sent = 0;
    next_drain = 100;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL; i++) key_pool[i] = KEY_W'($urandom);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty store
    issue(CMD_LOOKUP, 16'h1234, '0);
    issue(CMD_DUMP, '0, '0);
    issue(CMD_REMOVE, 16'h1234, '0);
    issue(CMD_CLEAR, '0, '0);
    // extremes, grade beyond 1000, duplicate keys
    issue(CMD_APPEND, '0, '0);
    issue(CMD_APPEND, '1, '1);
    issue(CMD_APPEND, 16'h1234, 10'd1000);
    issue(CMD_APPEND, 16'h1234, 10'd5);
    issue(CMD_LOOKUP, 16'h1234, '0);
    issue(CMD_LOOKUP, 16'hBEEF, '0);
    issue(CMD_LOOKUP, '1, '0);
    issue(CMD_DUMP, '0, '0);
    issue(CMD_REMOVE, 16'h1234, '0);
    issue(CMD_REMOVE, 16'hBEEF, '0);
    issue(CMD_LOOKUP, 16'h1234, '0);
    issue(CMD_CLEAR + CMD_W'(1), 16'h1234, '1);
    issue({CMD_W{1'b1}}, '1, '1);
    issue(CMD_DUMP, '0, '0);
    issue(CMD_CLEAR, '0, '0);
    issue(CMD_LOOKUP, '0, '0);
    drain();

    // fill past capacity, then walk the full store
    repeat (DEPTH + 2) issue(CMD_APPEND, pick_key(), pick_grade());
    issue(CMD_DUMP, '0, '0);
    issue(CMD_REMOVE, key_pool[$urandom_range(0, POOL - 1)], '0);
    sent = DEPTH + 4;

    while (sent < RANDOM_REQUESTS) begin
      kind = $urandom_range(0, 99);
      n = $urandom_range(1, 4);
      if (kind < 22) begin
        n = $urandom_range(1, 18);
        repeat (n) issue(CMD_APPEND, pick_key(), pick_grade());
        sent += n;
      end else if (kind < 45) begin
        repeat (n) issue(CMD_LOOKUP, pick_key(), GRADE_W'($urandom));
        sent += n;
      end else if (kind < 60) begin
        repeat (n) issue(CMD_REMOVE, pick_key(), GRADE_W'($urandom));
        sent += n;
      end else if (kind < 70) begin
        issue(CMD_DUMP, KEY_W'($urandom), GRADE_W'($urandom));
        sent++;
      end else if (kind < 74) begin
        issue(CMD_CLEAR, KEY_W'($urandom), GRADE_W'($urandom));
        sent++;
      end else if (kind < 90) begin
        issue(CMD_W'($urandom_range(0, CMD_CLEAR)), KEY_W'($urandom), GRADE_W'($urandom));
        sent++;
      end else begin
        issue(CMD_W'($urandom_range(CMD_CLEAR + 1, (1 << CMD_W) - 1)), KEY_W'($urandom),
              GRADE_W'($urandom));
      end
      if (sent >= next_drain) begin
        drain();
        next_drain += 100;
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #TIMEOUT;
    $display("Regression FAIL");
    $finish;
  end

endmodule
